@@ design/ght_pkg.sv @@
// ----------------------------------------------------------------------------
// Generational handle table package
// Shared codes, field widths and record types for the handle table.
// ----------------------------------------------------------------------------
`default_nettype none

package ght_pkg;

    localparam int GEN_W       = 32;
    localparam int HND_W       = 64;
    localparam int ASSET_W     = 64;
    localparam int SEED_W      = 64;
    localparam int OP_W        = 4;
    localparam int STATUS_W    = 3;
    localparam int LIVE_W      = 7;
    localparam int S_TDATA_W   = 200;
    localparam int M_TDATA_W   = 144;

    typedef enum logic [OP_W-1:0] {
        OP_CREATE   = 4'd0,
        OP_RELEASE  = 4'd1,
        OP_PLAY     = 4'd2,
        OP_PAUSE    = 4'd3,
        OP_STOP     = 4'd4,
        OP_RESTART  = 4'd5,
        OP_SET_SEED = 4'd6,
        OP_QUERY    = 4'd7,
        OP_LIST     = 4'd8
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_REQ   = 3'd1,
        ST_BAD_ASSET = 3'd2,
        ST_BAD_OWNER = 3'd3,
        ST_LIMIT     = 3'd4,
        ST_BAD_INST  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        PB_STOPPED = 2'd0,
        PB_PLAYING = 2'd1,
        PB_PAUSED  = 2'd2
    } pb_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_CR_WR,
        S_RES_A,
        S_RES_B,
        S_REL_WR,
        S_LST_RD,
        S_LST_GEN,
        S_LST_RES,
        S_EMIT
    } state_t;

    typedef struct packed {
        pb_t                pb;
        logic [SEED_W-1:0]  seed;
        logic [ASSET_W-1:0] asset;
    } dense_rec_t;

    typedef struct packed {
        status_t            status;
        logic [HND_W-1:0]   handle;
        logic               playing;
        logic [ASSET_W-1:0] asset;
        logic               last;
    } res_t;

endpackage

`default_nettype wire

@@ design/ght_ram.sv @@
// ----------------------------------------------------------------------------
// Handle table RAM
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ght_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            ram_reg[waddr] <= wdata;
        end
        rdata_reg <= ram_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ design/generational_handle_table_top.sv @@
// Steps from acceptance to the result word: create decodes, scans upward past occupied slots
// to the lowest free one and writes; release decodes, checks the slot and record, then writes
// back; other handle operations decode and check; a request rejected at decode or by the table
// lookup goes to emit; list reads each record and then its generation before each word.
// The input is ready again in the same cycle that the last result word is first valid.
// Reset marks all slots free with generation one through per-slot valid bits; ready at once.
// ----------------------------------------------------------------------------
// Generational handle table
// Slot map of effect instances with generation-checked handles, run by a small
// sequencer around simple dual-port table memories.
// ----------------------------------------------------------------------------
`default_nettype none

module generational_handle_table_top
    import ght_pkg::*;
#(
    parameter int MAX_INSTANCES = 64
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // op[3:0], handle[67:4], asset_id[131:68], asset_valid[132],
    // owner_alive[133], seed_value[197:134], zero fill above.
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // status[2:0], handle_out[66:3], playing[67], asset_out[131:68],
    // live_count[138:132], zero fill above.
    output logic      [M_TDATA_W-1:0] m_tdata,
    output logic                      m_tlast
);

    localparam int SW = (MAX_INSTANCES > 1) ? $clog2(MAX_INSTANCES) : 1;
    localparam int CW = $clog2(MAX_INSTANCES + 1);
    localparam int RW = $bits(dense_rec_t);

    state_t state_reg, state_next;

    logic [OP_W-1:0]    op_reg;
    logic [HND_W-1:0]   hnd_reg;
    logic [ASSET_W-1:0] asset_reg;
    logic               avalid_reg;
    logic               oalive_reg;
    logic [SEED_W-1:0]  seed_reg;

    logic [CW-1:0]            live_reg, live_next;
    logic [MAX_INSTANCES-1:0] slot_live_reg, slot_live_next;
    logic [MAX_INSTANCES-1:0] gen_vld_reg, gen_vld_next;
    logic                     gen_vld_q_reg;
    logic [SW-1:0]            sc_reg, sc_next;
    logic [SW-1:0]            k_reg, k_next;
    logic [SW-1:0]            d_reg, d_next;
    logic [GEN_W-1:0]         gen_reg, gen_next;
    res_t                     res_reg, res_next;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                 m_tlast_reg, m_tlast_next;

    logic [SW-1:0]    gen_raddr, gen_waddr;
    logic             gen_we;
    logic [GEN_W-1:0] gen_wdata, gen_q, gen_val;

    logic [SW-1:0] idx_waddr, idx_wdata, idx_q;
    logic          idx_we;

    logic [SW-1:0] rec_raddr, rec_waddr, dslot_wdata, dslot_q;
    logic          rec_we;
    dense_rec_t    rec_wdata, rec_q;
    logic [RW-1:0] rec_rdata;

    logic [GEN_W-1:0] enc_m1;
    logic [SW-1:0]    hslot;
    logic [SW-1:0]    last_idx;
    logic             hnd_ok;
    logic             accept;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    assign enc_m1   = hnd_reg[GEN_W-1:0] - GEN_W'(1);
    assign hslot    = enc_m1[SW-1:0];
    assign hnd_ok   = (hnd_reg[GEN_W-1:0] != '0)
                   && (hnd_reg[GEN_W-1:0] <= GEN_W'(MAX_INSTANCES))
                   && (hnd_reg[HND_W-1:GEN_W] != '0);
    assign last_idx = SW'(live_reg - CW'(1));
    assign gen_val  = gen_vld_q_reg ? gen_q : GEN_W'(1);
    assign rec_q    = dense_rec_t'(rec_rdata);

    ght_ram #(.DEPTH(MAX_INSTANCES), .WIDTH(GEN_W), .AW(SW)) u_gen_ram (
        .aclk  (aclk),
        .we    (gen_we),
        .waddr (gen_waddr),
        .wdata (gen_wdata),
        .raddr (gen_raddr),
        .rdata (gen_q)
    );

    ght_ram #(.DEPTH(MAX_INSTANCES), .WIDTH(SW), .AW(SW)) u_idx_ram (
        .aclk  (aclk),
        .we    (idx_we),
        .waddr (idx_waddr),
        .wdata (idx_wdata),
        .raddr (hslot),
        .rdata (idx_q)
    );

    ght_ram #(.DEPTH(MAX_INSTANCES), .WIDTH(SW), .AW(SW)) u_dslot_ram (
        .aclk  (aclk),
        .we    (rec_we),
        .waddr (rec_waddr),
        .wdata (dslot_wdata),
        .raddr (rec_raddr),
        .rdata (dslot_q)
    );

    ght_ram #(.DEPTH(MAX_INSTANCES), .WIDTH(RW), .AW(SW)) u_rec_ram (
        .aclk  (aclk),
        .we    (rec_we),
        .waddr (rec_waddr),
        .wdata (rec_wdata),
        .raddr (rec_raddr),
        .rdata (rec_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            live_reg      <= '0;
            slot_live_reg <= '0;
            gen_vld_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            live_reg      <= live_next;
            slot_live_reg <= slot_live_next;
            gen_vld_reg   <= gen_vld_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg     <= s_tdata[3:0];
            hnd_reg    <= s_tdata[67:4];
            asset_reg  <= s_tdata[131:68];
            avalid_reg <= s_tdata[132];
            oalive_reg <= s_tdata[133];
            seed_reg   <= s_tdata[197:134];
        end
        gen_vld_q_reg <= gen_vld_reg[gen_raddr];
        sc_reg        <= sc_next;
        k_reg         <= k_next;
        d_reg         <= d_next;
        gen_reg       <= gen_next;
        res_reg       <= res_next;
        m_tdata_reg   <= m_tdata_next;
        m_tlast_reg   <= m_tlast_next;
    end

    always_comb begin
        state_next     = state_reg;
        live_next      = live_reg;
        slot_live_next = slot_live_reg;
        gen_vld_next   = gen_vld_reg;
        sc_next        = sc_reg;
        k_next         = k_reg;
        d_next         = d_reg;
        gen_next       = gen_reg;
        res_next       = res_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tlast_next   = m_tlast_reg;

        gen_raddr   = hslot;
        gen_we      = 1'b0;
        gen_waddr   = hslot;
        gen_wdata   = gen_reg;
        idx_we      = 1'b0;
        idx_waddr   = hslot;
        idx_wdata   = d_reg;
        rec_raddr   = d_reg;
        rec_we      = 1'b0;
        rec_waddr   = d_reg;
        rec_wdata   = rec_q;
        dslot_wdata = hslot;

        case (state_reg)
            S_IDLE: begin
                sc_next = '0;
                k_next  = '0;
                if (s_tvalid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                res_next = '{ST_OK, hnd_reg, 1'b0, '0, 1'b1};
                case (op_reg)
                    OP_CREATE: begin
                        res_next.handle = '0;
                        if (!avalid_reg) begin
                            res_next.status = ST_BAD_ASSET;
                            state_next      = S_EMIT;
                        end else if (!oalive_reg) begin
                            res_next.status = ST_BAD_OWNER;
                            state_next      = S_EMIT;
                        end else if (live_reg >= CW'(MAX_INSTANCES)) begin
                            res_next.status = ST_LIMIT;
                            state_next      = S_EMIT;
                        end else begin
                            state_next = S_SCAN;
                        end
                    end
                    OP_LIST: begin
                        state_next = (live_reg == '0) ? S_IDLE : S_LST_RD;
                    end
                    default: begin
                        if (op_reg > OP_LIST) begin
                            res_next.status = ST_BAD_REQ;
                            state_next      = S_EMIT;
                        end else if (!hnd_ok) begin
                            res_next.status = ST_BAD_INST;
                            state_next      = S_EMIT;
                        end else begin
                            state_next = S_RES_A;
                        end
                    end
                endcase
            end
            S_SCAN: begin
                gen_raddr = sc_reg;
                if (!slot_live_reg[sc_reg]) begin
                    state_next = S_CR_WR;
                end else begin
                    sc_next = sc_reg + SW'(1);
                end
            end
            S_CR_WR: begin
                idx_we                 = 1'b1;
                idx_waddr              = sc_reg;
                idx_wdata              = SW'(live_reg);
                rec_we                 = 1'b1;
                rec_waddr              = SW'(live_reg);
                dslot_wdata            = sc_reg;
                rec_wdata              = '{PB_STOPPED, '0, asset_reg};
                slot_live_next[sc_reg] = 1'b1;
                live_next              = live_reg + CW'(1);
                res_next.handle        = {gen_val, GEN_W'(sc_reg) + GEN_W'(1)};
                state_next             = S_EMIT;
            end
            S_RES_A: begin
                gen_next  = gen_val;
                d_next    = idx_q;
                rec_raddr = idx_q;
                if ((gen_val == hnd_reg[HND_W-1:GEN_W]) && slot_live_reg[hslot]
                        && (CW'(idx_q) < live_reg)) begin
                    state_next = S_RES_B;
                end else begin
                    res_next.status = ST_BAD_INST;
                    state_next      = S_EMIT;
                end
            end
            S_RES_B: begin
                state_next = S_EMIT;
                if (dslot_q != hslot) begin
                    res_next.status = ST_BAD_INST;
                end else begin
                    case (op_reg)
                        OP_RELEASE: begin
                            rec_raddr  = last_idx;
                            state_next = S_REL_WR;
                        end
                        OP_PLAY, OP_RESTART: begin
                            rec_we       = 1'b1;
                            rec_wdata.pb = PB_PLAYING;
                        end
                        OP_PAUSE: begin
                            if (rec_q.pb != PB_PLAYING) begin
                                res_next.status = ST_BAD_REQ;
                            end else begin
                                rec_we       = 1'b1;
                                rec_wdata.pb = PB_PAUSED;
                            end
                        end
                        OP_STOP: begin
                            rec_we       = 1'b1;
                            rec_wdata.pb = PB_STOPPED;
                        end
                        OP_SET_SEED: begin
                            rec_we         = 1'b1;
                            rec_wdata.seed = seed_reg;
                        end
                        OP_QUERY: begin
                            res_next.playing = (rec_q.pb == PB_PLAYING);
                            res_next.asset   = rec_q.asset;
                        end
                        default: begin
                            res_next.status = ST_BAD_REQ;
                        end
                    endcase
                end
            end
            S_REL_WR: begin
                if (d_reg != last_idx) begin
                    rec_we      = 1'b1;
                    rec_waddr   = d_reg;
                    dslot_wdata = dslot_q;
                    rec_wdata   = rec_q;
                    idx_we      = 1'b1;
                    idx_waddr   = dslot_q;
                    idx_wdata   = d_reg;
                end
                gen_we    = 1'b1;
                gen_waddr = hslot;
                gen_wdata = (gen_reg == '1) ? GEN_W'(1) : gen_reg + GEN_W'(1);
                gen_vld_next[hslot]   = 1'b1;
                slot_live_next[hslot] = 1'b0;
                live_next             = live_reg - CW'(1);
                state_next            = S_EMIT;
            end
            S_LST_RD: begin
                rec_raddr  = k_reg;
                state_next = S_LST_GEN;
            end
            S_LST_GEN: begin
                rec_raddr  = k_reg;
                gen_raddr  = dslot_q;
                state_next = S_LST_RES;
            end
            S_LST_RES: begin
                res_next.status  = ST_OK;
                res_next.handle  = {gen_val, GEN_W'(dslot_q) + GEN_W'(1)};
                res_next.playing = 1'b0;
                res_next.asset   = '0;
                res_next.last    = (CW'(k_reg) == live_reg - CW'(1));
                k_next           = k_reg + SW'(1);
                state_next       = S_EMIT;
            end
            S_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'b0, LIVE_W'(live_reg), res_reg.asset, res_reg.playing,
                                     res_reg.handle, res_reg.status};
                    m_tlast_next  = res_reg.last;
                    if ((op_reg == OP_LIST) && !res_reg.last) begin
                        state_next = S_LST_RD;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_live_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        live_reg <= CW'(MAX_INSTANCES))
        else $error("live count exceeds table size");

    a_live_match: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(slot_live_reg) == int'(live_reg))
        else $error("live slot flags disagree with live count");

    a_gen_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        gen_we |-> (gen_wdata != '0))
        else $error("generation written as zero");

    a_create_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CR_WR) |-> !slot_live_reg[sc_reg])
        else $error("create allocates a live slot");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("word accepted while another is in progress");
`endif

endmodule

`default_nettype wire
